@@ design/swm_pkg.sv @@
// Shared constants and types for the snooped word memory target.
package swm_pkg;

	localparam int WORD_COUNT = 64;
	localparam int IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam logic [29:0] WORD_LIMIT = 30'(WORD_COUNT);
	localparam logic [31:0] WHOLE_END = 32'(WORD_COUNT * 4 - 1);

	localparam logic [2:0] OP_READ = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_RD_GRANT = 3'd2;
	localparam logic [2:0] OP_WR_GRANT = 3'd3;
	localparam logic [2:0] OP_SNOOP_SET = 3'd4;
	localparam logic [2:0] OP_SNOOP_WR = 3'd5;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ADDR = 3'd1;
	localparam logic [2:0] ST_BYTE_EN = 3'd2;
	localparam logic [2:0] ST_BURST = 3'd3;
	localparam logic [2:0] ST_REFUSED = 3'd4;
	localparam logic [2:0] ST_MISUSE = 3'd5;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic rsp_full;
	} stat_t;

endpackage

@@ design/swm_req_if.sv @@
// Request channel: valid/ready handshake with the request payload.
interface swm_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] address;
	logic [31:0] write_data;
	logic [7:0]  data_length;
	logic [7:0]  stream_width;
	logic        byte_enables_present;
	logic [31:0] snoop_range_end;

	modport source (output valid, opcode, address, write_data, data_length, stream_width,
		byte_enables_present, snoop_range_end, input ready);
	modport sink (input valid, opcode, address, write_data, data_length, stream_width,
		byte_enables_present, snoop_range_end, output ready);
endinterface

@@ design/swm_rsp_if.sv @@
// Response channel: valid/ready handshake with the response payload.
interface swm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] read_data;
	logic        invalidate_valid;
	logic [31:0] invalidate_start;
	logic [31:0] invalidate_end;
	logic        grant_read;
	logic        grant_write;
	logic [31:0] region_start;
	logic [31:0] region_end;

	modport source (output valid, status, read_data, invalidate_valid, invalidate_start,
		invalidate_end, grant_read, grant_write, region_start, region_end, input ready);
	modport sink (input valid, status, read_data, invalidate_valid, invalidate_start,
		invalidate_end, grant_read, grant_write, region_start, region_end, output ready);
endinterface

@@ design/swm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ design/swm_ctrl.sv @@
// Controller: accept a transaction, then execute and commit it into the response register.
module swm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              rsp_ready,
	input  swm_pkg::stat_t    stat,
	output logic              req_ready,
	output swm_pkg::cmd_t     cmd
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		req_ready = (state_q == S_IDLE);
		cmd.capture = 1'b0;
		cmd.commit = 1'b0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// response slot is free or drains this cycle
				if (!stat.rsp_full || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ design/swm_dp.sv @@
// Datapath: request registers, word store, snoop watch and response register.
module swm_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  swm_pkg::cmd_t    cmd,
	output swm_pkg::stat_t   stat,
	swm_req_if.sink          req,
	swm_rsp_if.source        rsp
);
	logic [2:0]  op_q;
	logic [31:0] addr_q;
	logic [31:0] wdata_q;
	logic [7:0]  len_q;
	logic [7:0]  wid_q;
	logic        be_q;
	logic [31:0] rend_q;
	logic [swm_pkg::IDX_W-1:0] idx_q;

	logic [swm_pkg::WORD_COUNT-1:0] wvalid_q;
	logic        armed_q;
	logic [31:0] first_q;
	logic [31:0] last_q;
	logic        rsp_valid_q;

	logic [31:0] ram_rdata;
	logic        ram_we;
	logic [2:0]  bus_st;
	logic        overlap;

	logic [2:0]  st_d;
	logic [31:0] rdata_d;
	logic        inv_d;
	logic [31:0] inv_start_d;
	logic [31:0] inv_end_d;
	logic        gr_d;
	logic        gw_d;
	logic [31:0] reg_start_d;
	logic [31:0] reg_end_d;
	logic        armed_d;

	swm_ram #(.WIDTH(32), .DEPTH(swm_pkg::WORD_COUNT), .AW(swm_pkg::IDX_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (wdata_q),
		.re    (cmd.capture),
		.raddr (req.address[2 +: swm_pkg::IDX_W]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= req.opcode;
			addr_q <= req.address;
			wdata_q <= req.write_data;
			len_q <= req.data_length;
			wid_q <= req.stream_width;
			be_q <= req.byte_enables_present;
			rend_q <= req.snoop_range_end;
			idx_q <= req.address[2 +: swm_pkg::IDX_W];
		end
	end

	always_comb begin
		if (addr_q[31:2] >= swm_pkg::WORD_LIMIT || addr_q[1:0] != 2'b00) begin
			bus_st = swm_pkg::ST_ADDR;
		end else if (be_q) begin
			bus_st = swm_pkg::ST_BYTE_EN;
		end else if (len_q != 8'd4 || wid_q != 8'd4) begin
			bus_st = swm_pkg::ST_BURST;
		end else begin
			bus_st = swm_pkg::ST_OK;
		end
	end

	// 33-bit compare so the end of the word cannot wrap
	assign overlap = armed_q && (({1'b0, addr_q} + 33'd4) > {1'b0, first_q})
		&& (addr_q <= last_q);

	always_comb begin
		st_d = swm_pkg::ST_OK;
		rdata_d = '0;
		inv_d = 1'b0;
		inv_start_d = '0;
		inv_end_d = '0;
		gr_d = 1'b0;
		gw_d = 1'b0;
		reg_start_d = '0;
		reg_end_d = '0;
		armed_d = armed_q;
		ram_we = 1'b0;
		case (op_q)
			swm_pkg::OP_READ: begin
				st_d = bus_st;
				if (bus_st == swm_pkg::ST_OK && wvalid_q[idx_q]) begin
					rdata_d = ram_rdata;
				end
			end
			swm_pkg::OP_WRITE: begin
				st_d = bus_st;
				if (bus_st == swm_pkg::ST_OK) begin
					ram_we = cmd.commit;
					if (overlap) begin
						inv_d = 1'b1;
						inv_start_d = first_q;
						inv_end_d = last_q;
						armed_d = 1'b0;
					end
				end
			end
			swm_pkg::OP_RD_GRANT: begin
				gr_d = 1'b1;
				reg_end_d = swm_pkg::WHOLE_END;
			end
			swm_pkg::OP_WR_GRANT: begin
				if (armed_q) begin
					st_d = swm_pkg::ST_REFUSED;
				end else begin
					gr_d = 1'b1;
					gw_d = 1'b1;
					reg_end_d = swm_pkg::WHOLE_END;
				end
			end
			swm_pkg::OP_SNOOP_SET: begin
				if (addr_q[1:0] != 2'b00) begin
					st_d = swm_pkg::ST_REFUSED;
				end else begin
					armed_d = 1'b1;
					inv_d = 1'b1;
					inv_start_d = addr_q;
					inv_end_d = rend_q;
					gr_d = 1'b1;
					reg_start_d = addr_q;
					reg_end_d = rend_q;
				end
			end
			swm_pkg::OP_SNOOP_WR: begin
				st_d = swm_pkg::ST_MISUSE;
			end
			default: begin
				st_d = swm_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			armed_q <= 1'b0;
			first_q <= '0;
			last_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				armed_q <= armed_d;
				if (ram_we) begin
					wvalid_q[idx_q] <= 1'b1;
				end
				if (op_q == swm_pkg::OP_SNOOP_SET) begin
					first_q <= addr_q;
					last_q <= rend_q;
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp.status <= st_d;
			rsp.read_data <= rdata_d;
			rsp.invalidate_valid <= inv_d;
			rsp.invalidate_start <= inv_start_d;
			rsp.invalidate_end <= inv_end_d;
			rsp.grant_read <= gr_d;
			rsp.grant_write <= gw_d;
			rsp.region_start <= reg_start_d;
			rsp.region_end <= reg_end_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign stat.rsp_full = rsp_valid_q;
endmodule

@@ design/snooped_word_memory_target.sv @@
// Snooped word memory target: top level joining controller and datapath.
//
// req carries one request transaction: bus read or write of a 32-bit word,
// a read or write grant request, or a snoop range set-up. rsp returns exactly
// one response transaction per request, in order, with status, read data,
// any invalidation range and any granted region.
// A request is taken at the edge where req.valid and req.ready are high. The
// following execute step reads the word store's registered output, evaluates
// the request and loads the response register, which raises rsp.valid.
// req.ready is high only between requests, so a new request is not taken until
// the previous one has executed; this is set by the word store's registered
// read port, read in the accept cycle and written in the execute cycle.
// If rsp.ready is low, the response holds and the execute step waits until
// the response register drains; no new request is taken meanwhile.
// Reset (arst_n low) disarms the snoop watch, clears its range, empties the
// response register and marks every word as zero through per-word valid bits,
// so no clearing pass is needed and requests are taken right after reset.
module snooped_word_memory_target (
	input  logic      clk,
	input  logic      arst_n,
	swm_req_if.sink   req,
	swm_rsp_if.source rsp
);
	swm_pkg::cmd_t  cmd;
	swm_pkg::stat_t stat;
	logic           ready;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.req_ready (ready),
		.cmd       (cmd)
	);

	swm_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

	assign req.ready = ready;
endmodule
